// ===== sv/pcc_pkg.sv =====
// Shared types, constants and the reference letter decoder for the pileup column classifier.
// Depends on nothing; every other file of the block imports it.
package pcc_pkg;

	localparam int COUNT_BITS_DEF = 20;
	localparam int FRAC_BITS_DEF  = 16;
	localparam int NUM_REGS       = 7;
	localparam int REG_IDX_BITS   = 3;
	localparam int BASES          = 5;

	typedef enum logic [REG_IDX_BITS-1:0] {
		REG_DISAGREE    = 3'd0,
		REG_INDEL       = 3'd1,
		REG_INS         = 3'd2,
		REG_DEL         = 3'd3,
		REG_POLYMER     = 3'd4,
		REG_INS_CON_MIN = 3'd5,
		REG_DEL_CON_MIN = 3'd6
	} pcc_reg_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_INS  = 2'd1,
		KIND_DEL  = 2'd2
	} pcc_kind_t;

	typedef enum logic [2:0] {
		BASE_A = 3'd0,
		BASE_C = 3'd1,
		BASE_G = 3'd2,
		BASE_T = 3'd3,
		BASE_N = 3'd4
	} pcc_base_t;

	typedef struct packed {
		logic poly;
		logic con;
		logic bad_ref;
	} pcc_ctl_t;

	typedef struct packed {
		logic disagree;
		logic zero_cov;
		logic high_indel;
		logic high_ins;
		logic high_del;
		logic high_con_indel;
		logic bad_ref;
	} pcc_flags_t;

	// base set of a reference letter, bit i for base i; zero for an unknown letter
	function automatic logic [BASES-1:0] ref_set(input logic [7:0] code);
		logic [7:0] c;
		logic [BASES-1:0] s;
		c = code;
		if (code >= "a" && code <= "z") begin
			c = code - 8'd32;
		end
		case (c)
			"A": s = 5'b00001;
			"C": s = 5'b00010;
			"G": s = 5'b00100;
			"T": s = 5'b01000;
			"N": s = 5'b10000;
			"M": s = 5'b00011;
			"R": s = 5'b00101;
			"S": s = 5'b00110;
			"V": s = 5'b00111;
			"W": s = 5'b01001;
			"Y": s = 5'b01010;
			"H": s = 5'b01011;
			"K": s = 5'b01100;
			"D": s = 5'b01101;
			"B": s = 5'b01110;
			default: s = 5'b00000;
		endcase
		return s;
	endfunction

endpackage

// ===== sv/pcc_front.sv =====
// First stage: coverage sums, pairwise maxima, reference decode and consensus test.
// Depends on pcc_pkg.
module pcc_front #(
	parameter int COUNT_BITS = pcc_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = pcc_pkg::FRAC_BITS_DEF
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic [7:0]              ref_code,
	input  logic [COUNT_BITS-1:0]   count_a,
	input  logic [COUNT_BITS-1:0]   count_c,
	input  logic [COUNT_BITS-1:0]   count_g,
	input  logic [COUNT_BITS-1:0]   count_t,
	input  logic [COUNT_BITS-1:0]   count_n,
	input  logic [COUNT_BITS-1:0]   ins_count,
	input  logic [COUNT_BITS-1:0]   del_covering,
	input  logic [COUNT_BITS-1:0]   del_events,
	input  logic                    polymer,
	input  logic [1:0]              consensus_kind,
	input  logic [FRAC_BITS:0]      consensus_ratio,
	input  logic [FRAC_BITS:0]      ins_con_min,
	input  logic [FRAC_BITS:0]      del_con_min,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [COUNT_BITS+2:0]   total_s1,
	output logic                    m01_idx_s1,
	output logic [COUNT_BITS-1:0]   m01_cnt_s1,
	output logic                    m23_idx_s1,
	output logic [COUNT_BITS-1:0]   m23_cnt_s1,
	output logic [COUNT_BITS-1:0]   cnt_n_s1,
	output logic [4:0]              set_s1,
	output logic [COUNT_BITS+2:0]   setsum_s1,
	output logic [COUNT_BITS:0]     indel_s1,
	output logic [COUNT_BITS-1:0]   ins_s1,
	output logic [COUNT_BITS-1:0]   delev_s1,
	output pcc_pkg::pcc_ctl_t       ctl_s1
);
	import pcc_pkg::*;

	localparam int TB = COUNT_BITS + 3;

	logic             valid_s1;
	logic             load;
	logic [BASES-1:0] set;
	logic [TB-1:0]    total;
	logic [TB-1:0]    setsum;
	logic             con;

	assign in_ready  = !valid_s1 || out_ready;
	assign load      = in_valid && in_ready;
	assign out_valid = valid_s1;

	assign set   = ref_set(ref_code);
	assign total = TB'(count_a) + TB'(count_c) + TB'(count_g) + TB'(count_t) + TB'(count_n);
	assign setsum = (set[BASE_A] ? TB'(count_a) : TB'(0)) + (set[BASE_C] ? TB'(count_c) : TB'(0))
		+ (set[BASE_G] ? TB'(count_g) : TB'(0)) + (set[BASE_T] ? TB'(count_t) : TB'(0))
		+ (set[BASE_N] ? TB'(count_n) : TB'(0));

	always_comb begin
		case (consensus_kind)
			KIND_INS: con = consensus_ratio >= ins_con_min;
			KIND_DEL: con = consensus_ratio >= del_con_min;
			default:  con = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			total_s1   <= total;
			m01_idx_s1 <= count_c > count_a;
			m01_cnt_s1 <= (count_c > count_a) ? count_c : count_a;
			m23_idx_s1 <= count_t > count_g;
			m23_cnt_s1 <= (count_t > count_g) ? count_t : count_g;
			cnt_n_s1   <= count_n;
			set_s1     <= set;
			setsum_s1  <= setsum;
			indel_s1   <= (COUNT_BITS+1)'(ins_count) + (COUNT_BITS+1)'(del_covering);
			ins_s1     <= ins_count;
			delev_s1   <= del_events;
			ctl_s1     <= '{poly: polymer, con: con, bad_ref: set == '0};
		end
	end

endmodule

// ===== sv/pcc_prod.sv =====
// Second stage: final maximum pick and the threshold-times-coverage products.
// Depends on pcc_pkg.
module pcc_prod #(
	parameter int COUNT_BITS = pcc_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = pcc_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [COUNT_BITS+2:0]             total_s1,
	input  logic                              m01_idx_s1,
	input  logic [COUNT_BITS-1:0]             m01_cnt_s1,
	input  logic                              m23_idx_s1,
	input  logic [COUNT_BITS-1:0]             m23_cnt_s1,
	input  logic [COUNT_BITS-1:0]             cnt_n_s1,
	input  logic [4:0]                        set_s1,
	input  logic [COUNT_BITS+2:0]             setsum_s1,
	input  logic [COUNT_BITS:0]               indel_s1,
	input  logic [COUNT_BITS-1:0]             ins_s1,
	input  logic [COUNT_BITS-1:0]             delev_s1,
	input  pcc_pkg::pcc_ctl_t                 ctl_s1,
	input  logic [FRAC_BITS:0]                dis_thr,
	input  logic [FRAC_BITS:0]                indel_thres,
	input  logic [FRAC_BITS:0]                ins_thres,
	input  logic [FRAC_BITS:0]                del_thres,
	input  logic [FRAC_BITS:0]                polymer_thres,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [COUNT_BITS+2:0]             total_s2,
	output logic [2:0]                        max_idx_s2,
	output logic [COUNT_BITS-1:0]             max_cnt_s2,
	output logic [COUNT_BITS+2:0]             setsum_s2,
	output logic                              inset_s2,
	output logic [COUNT_BITS:0]               indel_s2,
	output logic [COUNT_BITS-1:0]             ins_s2,
	output logic [COUNT_BITS-1:0]             delev_s2,
	output logic [COUNT_BITS+FRAC_BITS+3:0]   p_dis_s2,
	output logic [COUNT_BITS+FRAC_BITS+3:0]   p_indel_s2,
	output logic [COUNT_BITS+FRAC_BITS+3:0]   p_ins_s2,
	output logic [COUNT_BITS+FRAC_BITS+3:0]   p_del_s2,
	output pcc_pkg::pcc_ctl_t                 ctl_s2
);
	import pcc_pkg::*;

	localparam int PW = COUNT_BITS + FRAC_BITS + 4;

	logic                  valid_s2;
	logic                  load;
	logic [2:0]            mid_idx;
	logic [COUNT_BITS-1:0] mid_cnt;
	logic [2:0]            best_idx;
	logic [COUNT_BITS-1:0] best_cnt;
	logic [FRAC_BITS:0]    thr_indel;
	logic [FRAC_BITS:0]    thr_ins;
	logic [FRAC_BITS:0]    thr_del;

	assign in_ready  = !valid_s2 || out_ready;
	assign load      = in_valid && in_ready;
	assign out_valid = valid_s2;

	always_comb begin
		if (m23_cnt_s1 > m01_cnt_s1) begin
			mid_idx = m23_idx_s1 ? BASE_T : BASE_G;
			mid_cnt = m23_cnt_s1;
		end else begin
			mid_idx = m01_idx_s1 ? BASE_C : BASE_A;
			mid_cnt = m01_cnt_s1;
		end
		if (cnt_n_s1 > mid_cnt) begin
			best_idx = BASE_N;
			best_cnt = cnt_n_s1;
		end else begin
			best_idx = mid_idx;
			best_cnt = mid_cnt;
		end
	end

	assign thr_indel = ctl_s1.poly ? polymer_thres : indel_thres;
	assign thr_ins   = ctl_s1.poly ? polymer_thres : ins_thres;
	assign thr_del   = ctl_s1.poly ? polymer_thres : del_thres;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (in_ready) begin
			valid_s2 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			total_s2   <= total_s1;
			max_idx_s2 <= best_idx;
			max_cnt_s2 <= best_cnt;
			setsum_s2  <= setsum_s1;
			inset_s2   <= set_s1[best_idx];
			indel_s2   <= indel_s1;
			ins_s2     <= ins_s1;
			delev_s2   <= delev_s1;
			p_dis_s2   <= PW'(dis_thr) * PW'(total_s1);
			p_indel_s2 <= PW'(thr_indel) * PW'(total_s1);
			p_ins_s2   <= PW'(thr_ins) * PW'(total_s1);
			p_del_s2   <= PW'(thr_del) * PW'(total_s1);
			ctl_s2     <= ctl_s1;
		end
	end

endmodule

// ===== sv/pcc_judge.sv =====
// Third stage: ratio compares against the products and the output flags register.
// Depends on pcc_pkg.
module pcc_judge #(
	parameter int COUNT_BITS = pcc_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = pcc_pkg::FRAC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [COUNT_BITS+2:0]             total_s2,
	input  logic [2:0]                        max_idx_s2,
	input  logic [COUNT_BITS-1:0]             max_cnt_s2,
	input  logic [COUNT_BITS+2:0]             setsum_s2,
	input  logic                              inset_s2,
	input  logic [COUNT_BITS:0]               indel_s2,
	input  logic [COUNT_BITS-1:0]             ins_s2,
	input  logic [COUNT_BITS-1:0]             delev_s2,
	input  logic [COUNT_BITS+FRAC_BITS+3:0]   p_dis_s2,
	input  logic [COUNT_BITS+FRAC_BITS+3:0]   p_indel_s2,
	input  logic [COUNT_BITS+FRAC_BITS+3:0]   p_ins_s2,
	input  logic [COUNT_BITS+FRAC_BITS+3:0]   p_del_s2,
	input  pcc_pkg::pcc_ctl_t                 ctl_s2,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [COUNT_BITS+2:0]             total_s3,
	output logic [2:0]                        max_idx_s3,
	output logic [COUNT_BITS-1:0]             max_cnt_s3,
	output pcc_pkg::pcc_flags_t               flags_s3
);
	import pcc_pkg::*;

	localparam int PW = COUNT_BITS + FRAC_BITS + 4;

	logic       valid_s3;
	logic       load;
	logic       nz;
	logic       hi_indel;
	pcc_flags_t flags;

	assign in_ready  = !valid_s3 || out_ready;
	assign load      = in_valid && in_ready;
	assign out_valid = valid_s3;

	assign nz       = total_s2 != '0;
	assign hi_indel = nz && PW'({indel_s2, {FRAC_BITS{1'b0}}}) >= p_indel_s2;

	always_comb begin
		flags.disagree = !nz || PW'({max_cnt_s2, {FRAC_BITS{1'b0}}}) <= p_dis_s2
			|| ctl_s2.bad_ref || !inset_s2
			|| PW'({setsum_s2, {FRAC_BITS{1'b0}}}) <= p_dis_s2;
		flags.zero_cov       = total_s2 < (COUNT_BITS+3)'(3);
		flags.high_indel     = hi_indel;
		flags.high_ins       = nz && PW'({ins_s2, {FRAC_BITS{1'b0}}}) >= p_ins_s2;
		flags.high_del       = nz && PW'({delev_s2, {FRAC_BITS{1'b0}}}) >= p_del_s2;
		flags.high_con_indel = ctl_s2.con && hi_indel;
		flags.bad_ref        = ctl_s2.bad_ref;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			total_s3   <= total_s2;
			max_idx_s3 <= max_idx_s2;
			max_cnt_s3 <= max_cnt_s2;
			flags_s3   <= flags;
		end
	end

	ap_zero_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && total_s3 == '0 |-> flags_s3.disagree && !flags_s3.high_indel
			&& !flags_s3.high_ins && !flags_s3.high_del && max_cnt_s3 == '0)
		else $error("zero coverage beat with ratio flags set");

endmodule

// ===== sv/pileup_column_classifier_unit.sv =====
// Top level of the pileup column classifier: stream ports, threshold registers, three stages.
// Depends on pcc_pkg, pcc_front, pcc_prod and pcc_judge.
//
//  port group   dir  fields
//  s_*          in   one pileup column per beat, tdata + tuser
//  m_*          out  one classified column per beat, tdata
//  wr_*         in   threshold register writes, no read-back
//
// Three register stages: front, prod and judge; one beat per cycle while m_tready does not stall the output.
// Each stage holds its own valid bit, so a stall at m_tready fills bubbles before backing up.
// Reset clears the valid bits and loads the threshold registers with their defaults.
// The products in the second stage are the deepest logic between registers.
module pileup_column_classifier_unit #(
	parameter int COUNT_BITS = pcc_pkg::COUNT_BITS_DEF,
	parameter int FRAC_BITS  = pcc_pkg::FRAC_BITS_DEF,
	localparam int IN_RAW    = 8 + 8 * COUNT_BITS + 1 + FRAC_BITS + 1,
	localparam int IN_BITS   = ((IN_RAW + 7) / 8) * 8,
	localparam int OUT_RAW   = 2 * COUNT_BITS + 13,
	localparam int OUT_BITS  = ((OUT_RAW + 7) / 8) * 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	// ref_code, count_a, count_c, count_g, count_t, count_n, ins_count, del_covering,
	// del_events, polymer, consensus_ratio, zero pad
	input  logic [IN_BITS-1:0]               s_tdata,
	// consensus_kind
	input  logic [1:0]                       s_tuser,
	output logic                             m_tvalid,
	input  logic                             m_tready,
	// coverage, max_index, max_count, disagree, zero_cov, high_indel, high_ins, high_del,
	// high_con_indel, bad_ref, zero pad
	output logic [OUT_BITS-1:0]              m_tdata,
	input  logic                             wr_en,
	input  logic [pcc_pkg::REG_IDX_BITS-1:0] wr_index,
	input  logic [FRAC_BITS:0]               wr_data
);
	import pcc_pkg::*;

	localparam int CB = COUNT_BITS;
	localparam int TW = FRAC_BITS + 1;
	localparam int PW = COUNT_BITS + FRAC_BITS + 4;
	localparam logic [TW-1:0] DIS_RST  = TW'(((7 << FRAC_BITS) + 5) / 10);
	localparam logic [TW-1:0] IND_RST  = TW'(((3 << FRAC_BITS) + 5) / 10);
	localparam logic [TW-1:0] POLY_RST = TW'(((6 << FRAC_BITS) + 5) / 10);
	localparam logic [TW-1:0] CON_RST  = TW'(1 << (FRAC_BITS - 1));
	localparam int O_CNT   = 8;
	localparam int O_INS   = O_CNT + 5 * CB;
	localparam int O_DCOV  = O_INS + CB;
	localparam int O_DEV   = O_DCOV + CB;
	localparam int O_POLY  = O_DEV + CB;
	localparam int O_RATIO = O_POLY + 1;

	logic [TW-1:0] dis_thr_q;
	logic [TW-1:0] indel_thres_q;
	logic [TW-1:0] ins_thres_q;
	logic [TW-1:0] del_thres_q;
	logic [TW-1:0] polymer_thres_q;
	logic [TW-1:0] ins_con_min_q;
	logic [TW-1:0] del_con_min_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dis_thr_q       <= DIS_RST;
			indel_thres_q   <= IND_RST;
			ins_thres_q     <= IND_RST;
			del_thres_q     <= IND_RST;
			polymer_thres_q <= POLY_RST;
			ins_con_min_q   <= CON_RST;
			del_con_min_q   <= CON_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_DISAGREE:    dis_thr_q       <= wr_data;
				REG_INDEL:       indel_thres_q   <= wr_data;
				REG_INS:         ins_thres_q     <= wr_data;
				REG_DEL:         del_thres_q     <= wr_data;
				REG_POLYMER:     polymer_thres_q <= wr_data;
				REG_INS_CON_MIN: ins_con_min_q   <= wr_data;
				REG_DEL_CON_MIN: del_con_min_q   <= wr_data;
				default: ;
			endcase
		end
	end

	logic            v1, r1, v2, r2;
	logic [CB+2:0]   total_s1, setsum_s1;
	logic            m01_idx_s1, m23_idx_s1;
	logic [CB-1:0]   m01_cnt_s1, m23_cnt_s1, cnt_n_s1, ins_s1, delev_s1;
	logic [4:0]      set_s1;
	logic [CB:0]     indel_s1;
	pcc_ctl_t        ctl_s1;

	pcc_front #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (s_tvalid),
		.in_ready        (s_tready),
		.ref_code        (s_tdata[7:0]),
		.count_a         (s_tdata[O_CNT +: CB]),
		.count_c         (s_tdata[O_CNT + CB +: CB]),
		.count_g         (s_tdata[O_CNT + 2 * CB +: CB]),
		.count_t         (s_tdata[O_CNT + 3 * CB +: CB]),
		.count_n         (s_tdata[O_CNT + 4 * CB +: CB]),
		.ins_count       (s_tdata[O_INS +: CB]),
		.del_covering    (s_tdata[O_DCOV +: CB]),
		.del_events      (s_tdata[O_DEV +: CB]),
		.polymer         (s_tdata[O_POLY]),
		.consensus_kind  (s_tuser),
		.consensus_ratio (s_tdata[O_RATIO +: TW]),
		.ins_con_min     (ins_con_min_q),
		.del_con_min     (del_con_min_q),
		.out_valid       (v1),
		.out_ready       (r1),
		.total_s1        (total_s1),
		.m01_idx_s1      (m01_idx_s1),
		.m01_cnt_s1      (m01_cnt_s1),
		.m23_idx_s1      (m23_idx_s1),
		.m23_cnt_s1      (m23_cnt_s1),
		.cnt_n_s1        (cnt_n_s1),
		.set_s1          (set_s1),
		.setsum_s1       (setsum_s1),
		.indel_s1        (indel_s1),
		.ins_s1          (ins_s1),
		.delev_s1        (delev_s1),
		.ctl_s1          (ctl_s1)
	);

	logic [CB+2:0]   total_s2, setsum_s2;
	logic [2:0]      max_idx_s2;
	logic [CB-1:0]   max_cnt_s2, ins_s2, delev_s2;
	logic            inset_s2;
	logic [CB:0]     indel_s2;
	logic [PW-1:0]   p_dis_s2, p_indel_s2, p_ins_s2, p_del_s2;
	pcc_ctl_t        ctl_s2;

	pcc_prod #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_prod (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (v1),
		.in_ready       (r1),
		.total_s1       (total_s1),
		.m01_idx_s1     (m01_idx_s1),
		.m01_cnt_s1     (m01_cnt_s1),
		.m23_idx_s1     (m23_idx_s1),
		.m23_cnt_s1     (m23_cnt_s1),
		.cnt_n_s1       (cnt_n_s1),
		.set_s1         (set_s1),
		.setsum_s1      (setsum_s1),
		.indel_s1       (indel_s1),
		.ins_s1         (ins_s1),
		.delev_s1       (delev_s1),
		.ctl_s1         (ctl_s1),
		.dis_thr        (dis_thr_q),
		.indel_thres    (indel_thres_q),
		.ins_thres      (ins_thres_q),
		.del_thres      (del_thres_q),
		.polymer_thres  (polymer_thres_q),
		.out_valid      (v2),
		.out_ready      (r2),
		.total_s2       (total_s2),
		.max_idx_s2     (max_idx_s2),
		.max_cnt_s2     (max_cnt_s2),
		.setsum_s2      (setsum_s2),
		.inset_s2       (inset_s2),
		.indel_s2       (indel_s2),
		.ins_s2         (ins_s2),
		.delev_s2       (delev_s2),
		.p_dis_s2       (p_dis_s2),
		.p_indel_s2     (p_indel_s2),
		.p_ins_s2       (p_ins_s2),
		.p_del_s2       (p_del_s2),
		.ctl_s2         (ctl_s2)
	);

	logic [CB+2:0]   total_s3;
	logic [2:0]      max_idx_s3;
	logic [CB-1:0]   max_cnt_s3;
	pcc_flags_t      flags_s3;

	pcc_judge #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_judge (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (v2),
		.in_ready   (r2),
		.total_s2   (total_s2),
		.max_idx_s2 (max_idx_s2),
		.max_cnt_s2 (max_cnt_s2),
		.setsum_s2  (setsum_s2),
		.inset_s2   (inset_s2),
		.indel_s2   (indel_s2),
		.ins_s2     (ins_s2),
		.delev_s2   (delev_s2),
		.p_dis_s2   (p_dis_s2),
		.p_indel_s2 (p_indel_s2),
		.p_ins_s2   (p_ins_s2),
		.p_del_s2   (p_del_s2),
		.ctl_s2     (ctl_s2),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.total_s3   (total_s3),
		.max_idx_s3 (max_idx_s3),
		.max_cnt_s3 (max_cnt_s3),
		.flags_s3   (flags_s3)
	);

	assign m_tdata = OUT_BITS'({flags_s3.bad_ref, flags_s3.high_con_indel, flags_s3.high_del,
		flags_s3.high_ins, flags_s3.high_indel, flags_s3.zero_cov, flags_s3.disagree,
		max_cnt_s3, max_idx_s3, total_s3});

	ap_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> m_tvalid && !m_tready && v1 && v2)
		else $error("input stalled with a bubble in the pipeline");

	ap_bad_ref_dis: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && flags_s3.bad_ref |-> flags_s3.disagree)
		else $error("unknown reference without disagree");

	ap_con_indel: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && flags_s3.high_con_indel |-> flags_s3.high_indel)
		else $error("consensus indel without high indel");

	ap_max_le_total: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (CB+3)'(max_cnt_s3) <= total_s3 && max_idx_s3 <= 3'(BASE_N))
		else $error("maximum count exceeds coverage");

endmodule

// ===== tb/tb_pileup_column_classifier_unit.sv =====
// Self-checking testbench for pileup_column_classifier_unit: directed and random pileup columns,
// threshold sweeps and random stalls on both streams, with an in-bench classifier to compare.
// Depends on pcc_pkg and the pileup_column_classifier_unit RTL.
module tb_pileup_column_classifier_unit;
	import pcc_pkg::*;

	localparam int FRAC           = FRAC_BITS_DEF;
	localparam int PIPE_DEPTH     = 3;
	localparam int PHASES         = 8;
	localparam int COLUMNS_PER_PHASE = 244;
	localparam int HOLD_AT_BEAT   = 400;
	localparam int HOLD_CYCLES    = 150;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam logic [2:0] REG_SPARE  = 3'd7;
	localparam logic [1:0] KIND_SPARE = 2'd3;
	localparam logic [16:0] ONE_Q     = 17'h10000;
	localparam logic [16:0] THR_MAX   = 17'h1FFFF;
	localparam logic [4:0] HAS_A = 5'b1 << BASE_A;
	localparam logic [4:0] HAS_C = 5'b1 << BASE_C;
	localparam logic [4:0] HAS_G = 5'b1 << BASE_G;
	localparam logic [4:0] HAS_T = 5'b1 << BASE_T;
	localparam logic [4:0] HAS_N = 5'b1 << BASE_N;

	typedef struct packed {
		logic [5:0]  pad;
		logic [16:0] consensus_ratio;
		logic        polymer;
		logic [19:0] del_events;
		logic [19:0] del_covering;
		logic [19:0] ins_count;
		logic [19:0] count_n;
		logic [19:0] count_t;
		logic [19:0] count_g;
		logic [19:0] count_c;
		logic [19:0] count_a;
		logic [7:0]  ref_code;
	} pileup_beat_t;

	typedef struct packed {
		logic [2:0]  pad;
		logic        bad_ref;
		logic        high_con_indel;
		logic        high_del;
		logic        high_ins;
		logic        high_indel;
		logic        zero_cov;
		logic        disagree;
		logic [19:0] max_count;
		logic [2:0]  max_index;
		logic [22:0] coverage;
	} column_result_t;

	typedef struct {
		pileup_beat_t beat;
		logic [1:0]   kind;
	} column_item_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [$bits(pileup_beat_t)-1:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [$bits(column_result_t)-1:0] m_tdata;
	logic wr_en = 1'b0;
	logic [2:0] wr_index = '0;
	logic [16:0] wr_data = '0;

	logic [16:0] thr_q [NUM_REGS];
	string base_letters = "ACGTNMRSVWYHKDB";

	column_item_t   pending_columns [$];
	column_result_t expected_verdicts [$];
	column_item_t   on_bus;
	column_result_t got_verdict, want_verdict;
	int columns_queued = 0;
	int columns_accepted = 0;
	int verdicts_seen = 0;
	int mismatch_count = 0;
	int send_gap = 0;
	int recv_stall = 0;
	int hold_left = 0;
	int quiet_cycles = 0;
	bit fast_send = 1'b0;
	bit fast_recv = 1'b0;

	pileup_column_classifier_unit DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [16:0] default_threshold(input int r);
		case (r)
			REG_DISAGREE: return 17'd45875;
			REG_POLYMER: return 17'd39322;
			REG_INS_CON_MIN, REG_DEL_CON_MIN: return ONE_Q >> 1;
			default: return 17'd19661;
		endcase
	endfunction

	function automatic logic [4:0] letter_bases(input logic [7:0] code, output logic plain);
		logic [7:0] up;
		up = (code >= "a" && code <= "z") ? code - 8'd32 : code;
		plain = 1'b0;
		case (up)
			"A": begin plain = 1'b1; return HAS_A; end
			"C": begin plain = 1'b1; return HAS_C; end
			"G": begin plain = 1'b1; return HAS_G; end
			"T": begin plain = 1'b1; return HAS_T; end
			"N": begin plain = 1'b1; return HAS_N; end
			"M": return HAS_A | HAS_C;
			"R": return HAS_A | HAS_G;
			"S": return HAS_C | HAS_G;
			"V": return HAS_A | HAS_C | HAS_G;
			"W": return HAS_A | HAS_T;
			"Y": return HAS_C | HAS_T;
			"H": return HAS_A | HAS_C | HAS_T;
			"K": return HAS_G | HAS_T;
			"D": return HAS_A | HAS_G | HAS_T;
			"B": return HAS_C | HAS_G | HAS_T;
			default: return 5'b0;
		endcase
	endfunction

	function automatic logic ratio_reaches(input logic [63:0] num, input logic [63:0] total,
			input logic [16:0] thr);
		return total != 0 && (num << FRAC) >= 64'(thr) * total;
	endfunction

	function automatic column_result_t classify_column(input pileup_beat_t b, input logic [1:0] kind);
		column_result_t r;
		logic [63:0] cnt [5];
		logic [63:0] total, top, in_set;
		logic [4:0] bases;
		logic plain, agree, con;
		int idx;
		cnt[0] = 64'(b.count_a);
		cnt[1] = 64'(b.count_c);
		cnt[2] = 64'(b.count_g);
		cnt[3] = 64'(b.count_t);
		cnt[4] = 64'(b.count_n);
		bases = letter_bases(b.ref_code, plain);
		total = 0;
		in_set = 0;
		top = cnt[0];
		idx = 0;
		for (int i = 0; i < BASES; i++) begin
			total += cnt[i];
			if (bases[i])
				in_set += cnt[i];
			if (cnt[i] > top) begin
				top = cnt[i];
				idx = i;
			end
		end
		agree = total != 0 && (top << FRAC) > 64'(thr_q[REG_DISAGREE]) * total
			&& bases != 0 && bases[idx]
			&& (plain || (in_set << FRAC) > 64'(thr_q[REG_DISAGREE]) * total);
		if (kind == KIND_INS)
			con = b.consensus_ratio >= thr_q[REG_INS_CON_MIN];
		else if (kind == KIND_DEL)
			con = b.consensus_ratio >= thr_q[REG_DEL_CON_MIN];
		else
			con = 1'b0;
		r = '0;
		r.coverage = total[22:0];
		r.max_index = idx[2:0];
		r.max_count = top[19:0];
		r.disagree = !agree;
		r.zero_cov = total < 3;
		r.high_indel = ratio_reaches(64'(b.ins_count) + 64'(b.del_covering), total,
			b.polymer ? thr_q[REG_POLYMER] : thr_q[REG_INDEL]);
		r.high_ins = ratio_reaches(64'(b.ins_count), total,
			b.polymer ? thr_q[REG_POLYMER] : thr_q[REG_INS]);
		r.high_del = ratio_reaches(64'(b.del_events), total,
			b.polymer ? thr_q[REG_POLYMER] : thr_q[REG_DEL]);
		r.high_con_indel = con && r.high_indel;
		r.bad_ref = bases == 0;
		return r;
	endfunction

	function automatic pileup_beat_t column_of(input logic [7:0] letter,
			input logic [19:0] a, input logic [19:0] c, input logic [19:0] g,
			input logic [19:0] t, input logic [19:0] n, input logic [19:0] ins,
			input logic [19:0] delcov, input logic [19:0] delev, input logic poly,
			input logic [16:0] ratio);
		pileup_beat_t b;
		b = '0;
		b.ref_code = letter;
		b.count_a = a;
		b.count_c = c;
		b.count_g = g;
		b.count_t = t;
		b.count_n = n;
		b.ins_count = ins;
		b.del_covering = delcov;
		b.del_events = delev;
		b.polymer = poly;
		b.consensus_ratio = ratio;
		return b;
	endfunction

	function automatic pileup_beat_t random_column();
		pileup_beat_t b;
		logic [19:0] cnt [5];
		int unsigned shape, lim, lead;
		b = '0;
		shape = $urandom_range(0, 9);
		lim = (32'd1 << $urandom_range(0, 20)) - 1;
		lead = $urandom_range(0, 4);
		for (int i = 0; i < BASES; i++) begin
			if (shape == 0)
				cnt[i] = 20'($urandom_range(0, 2));
			else if (shape == 1)
				cnt[i] = 20'($urandom);
			else if (i == lead)
				cnt[i] = 20'($urandom_range(0, lim));
			else
				cnt[i] = 20'($urandom_range(0, lim >> $urandom_range(0, 4)));
		end
		b.count_a = cnt[0];
		b.count_c = cnt[1];
		b.count_g = cnt[2];
		b.count_t = cnt[3];
		b.count_n = cnt[4];
		if (shape == 1) begin
			b.ins_count = 20'($urandom);
			b.del_covering = 20'($urandom);
			b.del_events = 20'($urandom);
		end else begin
			b.ins_count = 20'($urandom_range(0, lim >> $urandom_range(0, 3)));
			b.del_covering = 20'($urandom_range(0, lim >> $urandom_range(0, 3)));
			b.del_events = 20'($urandom_range(0, lim >> $urandom_range(0, 3)));
		end
		if ($urandom_range(0, 9) == 0)
			b.ref_code = 8'($urandom);
		else
			b.ref_code = base_letters[$urandom_range(0, 14)] | ($urandom_range(0, 1) ? 8'h20 : 8'h00);
		b.polymer = 1'($urandom_range(0, 1));
		b.consensus_ratio = 17'($urandom_range(0, 3) == 0 ? $urandom_range(0, 131071)
			: $urandom_range(0, 65536));
		return b;
	endfunction

	task automatic queue_column(input pileup_beat_t b, input logic [1:0] kind);
		column_item_t item;
		item.beat = b;
		item.kind = kind;
		pending_columns.insert(pending_columns.size(), item);
		columns_queued++;
	endtask

	task automatic write_threshold(input logic [2:0] idx, input logic [16:0] value);
		@(posedge clk);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= value;
		if (idx < NUM_REGS)
			thr_q[idx] = value;
		@(posedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic wait_idle();
		while (columns_accepted != columns_queued || expected_verdicts.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH * 2) @(posedge clk);
	endtask

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("mismatch at beat %0d, %s: got %0h expected %0h", verdicts_seen, what, got, want);
		mismatch_count++;
	endtask

	task automatic compare_field(input string what, input logic [63:0] got, input logic [63:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	// drive input beats, predict at acceptance
	always @(posedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			send_gap = 0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_verdicts.insert(expected_verdicts.size(),
					classify_column(on_bus.beat, on_bus.kind));
				columns_accepted++;
			end
			if (!s_tvalid || s_tready) begin
				if (send_gap > 0) begin
					send_gap--;
					s_tvalid <= 1'b0;
				end else if (pending_columns.size() > 0) begin
					on_bus = pending_columns.pop_front();
					s_tdata <= on_bus.beat;
					s_tuser <= on_bus.kind;
					s_tvalid <= 1'b1;
					send_gap = fast_send ? 0 : $urandom_range(0, 9);
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	// check output beats, stall at random, hold off once
	always @(posedge clk) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			recv_stall = 0;
			hold_left = 0;
		end else begin
			if (m_tvalid && m_tready) begin
				got_verdict = column_result_t'(m_tdata);
				if (expected_verdicts.size() == 0) begin
					report_mismatch("beat with nothing pending", 64'(got_verdict.coverage), 0);
				end else begin
					want_verdict = expected_verdicts.pop_front();
					compare_field("coverage", 64'(got_verdict.coverage),
						64'(want_verdict.coverage));
					compare_field("max_index", 64'(got_verdict.max_index),
						64'(want_verdict.max_index));
					compare_field("max_count", 64'(got_verdict.max_count),
						64'(want_verdict.max_count));
					compare_field("disagree", 64'(got_verdict.disagree),
						64'(want_verdict.disagree));
					compare_field("zero_cov", 64'(got_verdict.zero_cov),
						64'(want_verdict.zero_cov));
					compare_field("high_indel", 64'(got_verdict.high_indel),
						64'(want_verdict.high_indel));
					compare_field("high_ins", 64'(got_verdict.high_ins),
						64'(want_verdict.high_ins));
					compare_field("high_del", 64'(got_verdict.high_del),
						64'(want_verdict.high_del));
					compare_field("high_con_indel", 64'(got_verdict.high_con_indel),
						64'(want_verdict.high_con_indel));
					compare_field("bad_ref", 64'(got_verdict.bad_ref),
						64'(want_verdict.bad_ref));
				end
				verdicts_seen++;
				recv_stall = fast_recv ? 0 : $urandom_range(0, 9);
				if (verdicts_seen == HOLD_AT_BEAT)
					hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else if (recv_stall > 0) begin
				recv_stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	initial begin
		logic [7:0] letter;
		logic [4:0] bases;
		logic plain;
		logic [16:0] value;
		for (int r = 0; r < NUM_REGS; r++)
			thr_q[r] = default_threshold(r);
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		queue_column(column_of("A", 0, 0, 0, 0, 0, 0, 0, 0, 1'b0, 17'd0), KIND_NONE);
		queue_column(column_of("n", '1, '1, '1, '1, '1, '1, '1, '1, 1'b1, THR_MAX), KIND_INS);
		for (int i = 0; i < 15; i++) begin
			letter = base_letters[i] | ((i % 2) ? 8'h20 : 8'h00);
			bases = letter_bases(letter, plain);
			queue_column(column_of(letter,
				bases[0] ? 20'(30 + i) : 20'd1, bases[1] ? 20'(30 + i) : 20'd1,
				bases[2] ? 20'(30 + i) : 20'd1, bases[3] ? 20'(30 + i) : 20'd1,
				bases[4] ? 20'(30 + i) : 20'd1,
				20'(i), 20'd5, 20'((i % 4) * 4), 1'(i % 2), 17'(16384 * (i % 5))), 2'(i % 3));
		end
		queue_column(column_of("X", 20, 0, 0, 0, 0, 8, 0, 8, 1'b0, ONE_Q), KIND_INS);
		queue_column(column_of(8'h00, 0, 20, 0, 0, 0, 0, 0, 0, 1'b0, 17'd0), KIND_NONE);
		queue_column(column_of(8'hFF, 0, 0, 2, 0, 0, 1, 1, 1, 1'b1, 17'd1), KIND_DEL);
		queue_column(column_of("C", 50, 50, 0, 0, 0, 0, 0, 0, 1'b0, 17'd0), KIND_NONE);
		queue_column(column_of("a", 10, 0, 0, 0, 0, 10, 0, 0, 1'b0, ONE_Q), KIND_SPARE);
		queue_column(column_of("T", 0, 0, 0, 10, 0, 0, 10, 10, 1'b0, ONE_Q >> 1), KIND_DEL);
		queue_column(column_of("g", 0, 0, 10, 0, 0, 10, 0, 0, 1'b1, (ONE_Q >> 1) - 1), KIND_INS);
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			fast_send = (p % 3 == 2);
			fast_recv = (p % 4 == 1);
			for (int r = 0; r < NUM_REGS; r++) begin
				case (p)
					0: value = 17'd0;
					1: value = ONE_Q;
					2: value = THR_MAX;
					3: value = default_threshold(r);
					4: value = (r == REG_DISAGREE) ? ONE_Q >> 1 : ONE_Q >> 2;
					default: value = 17'($urandom_range(0, 7) == 0 ? $urandom_range(65537, 131071)
						: $urandom_range(0, 65536));
				endcase
				write_threshold(r[2:0], value);
			end
			if (p == 0)
				write_threshold(REG_SPARE, 17'h1ABCD);
			for (int n = 0; n < COLUMNS_PER_PHASE; n++)
				queue_column(random_column(), 2'($urandom_range(0, 3)));
			wait_idle();
		end

		if (mismatch_count == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule

// ===== files.f =====
sv/pcc_pkg.sv
sv/pcc_front.sv
sv/pcc_prod.sv
sv/pcc_judge.sv
sv/pileup_column_classifier_unit.sv
tb/tb_pileup_column_classifier_unit.sv
